// ===== design/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg: shared types, constants and step functions
// Work-word layout between the front and back ends, CORDIC arctan table,
// one digit step of the integer square root and one CORDIC vectoring step.
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam int CW_MAX      = 32;   // widest coordinate the datapath is sized for
    localparam int SQ_STEPS    = 32;   // root bits per square root
    localparam int RAD_W       = 64;   // radicand width
    localparam int ROOT_W      = 32;
    localparam int ZF_W        = 56;   // scaled |z| for the polar CORDIC
    localparam int CXW         = 60;   // CORDIC x/y width
    localparam int AW          = 34;   // angle accumulator, degrees Q24
    localparam int QUEUE_DEPTH = 4;

    localparam int RADIUS_W = 24;
    localparam int POLAR_W  = 24;
    localparam int AZIM_W   = 26;

    localparam logic [RADIUS_W-1:0]  RADIUS_MAX = 24'hFFFFFF;
    localparam logic signed [AW-1:0] DEG180_Q24 = 34'sd3019898880;
    localparam logic signed [AW-1:0] DEG90_Q16  = 34'sd5898240;
    localparam logic signed [AW-1:0] DEG180_Q16 = 34'sd11796480;
    localparam logic signed [AW-1:0] POLAR_MAX  = 34'sd11796480;
    localparam logic signed [AW-1:0] AZ_MIN     = -34'sd5898240;
    localparam logic signed [AW-1:0] AZ_MAX     = 34'sd17694720;
    localparam logic signed [AW-1:0] RND_HALF   = 34'sd128;

    typedef struct packed {
        logic zero;
        logic n2_zero;
        logic z_zero;
        logic z_pos;
        logic x_zero;
        logic y_zero;
        logic x_neg;
    } t_flags;

    typedef struct packed {
        logic signed [CXW-1:0] x;
        logic signed [CXW-1:0] y;
        logic signed [AW-1:0]  a;
    } t_rot;

    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    // word handed from front end to back end
    typedef struct packed {
        t_flags            flags;
        logic [RAD_W-1:0]  n3;
        logic [RAD_W-1:0]  m;
        logic [ZF_W-1:0]   zf;
        t_rot              azi;
    } t_work;

    typedef struct packed {
        t_flags           flags;
        t_sq              rad_sq;
        t_sq              pol_sq;
        logic [ZF_W-1:0]  zf;
        t_rot             pol_rot;
        t_rot             azi_rot;
    } t_stage;

    typedef struct packed {
        t_flags               flags;
        logic [ROOT_W:0]      rad;
        logic signed [AW-1:0] pol;
        logic signed [AW-1:0] azi;
    } t_fin;

    // atan(2^-i) in degrees, Q24
    function automatic logic signed [AW-1:0] atan_q24(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:  v = 34'sd754974720;
            1:  v = 34'sd445687602;
            2:  v = 34'sd235489088;
            3:  v = 34'sd119537938;
            4:  v = 34'sd60000934;
            5:  v = 34'sd30029717;
            6:  v = 34'sd15018523;
            7:  v = 34'sd7509720;
            8:  v = 34'sd3754917;
            9:  v = 34'sd1877466;
            10: v = 34'sd938734;
            11: v = 34'sd469367;
            12: v = 34'sd234684;
            13: v = 34'sd117342;
            14: v = 34'sd58671;
            15: v = 34'sd29335;
            16: v = 34'sd14668;
            17: v = 34'sd7334;
            18: v = 34'sd3667;
            19: v = 34'sd1833;
            20: v = 34'sd917;
            21: v = 34'sd458;
            22: v = 34'sd229;
            23: v = 34'sd115;
            24: v = 34'sd57;
            25: v = 34'sd29;
            26: v = 34'sd14;
            27: v = 34'sd7;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // vectoring step: drive y toward zero
    function automatic t_rot cordic_step(input t_rot v, input int i);
        t_rot                  o;
        logic signed [CXW-1:0] dx;
        logic signed [CXW-1:0] dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (!v.y[CXW-1]) begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.a = v.a + atan_q24(i);
        end else begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.a = v.a - atan_q24(i);
        end
        return o;
    endfunction

    // one root bit at weight 2^b; rem tracks n - root^2
    function automatic t_sq sqrt_step(input t_sq v, input int b);
        t_sq              o;
        logic [RAD_W+1:0] trial;
        trial = ((RAD_W + 2)'(v.root) << (b + 1)) + ((RAD_W + 2)'(1) << (2 * b));
        o = v;
        if ({2'b00, v.rem} >= trial) begin
            o.rem  = v.rem - trial[RAD_W-1:0];
            o.root = v.root | (ROOT_W'(1) << b);
        end
        return o;
    endfunction

    function automatic logic [5:0] msb_index(input logic [RAD_W-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = 0; i < RAD_W; i++) begin
            if (v[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [5:0] bit_len(input logic [CW_MAX-1:0] v);
        logic [5:0] len;
        len = '0;
        for (int i = 0; i < CW_MAX; i++) begin
            if (v[i]) begin
                len = 6'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

// ===== design/c2s_front.sv =====
// ----------------------------------------------------------------------------
// c2s_front: input side
// Takes words, forms magnitudes, squares and sums, classifies the special
// cases and normalizes the polar square-root operand. Five register stages.
// ----------------------------------------------------------------------------
module c2s_front #(
    parameter int COORD_WIDTH = c2s_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vec_x,
    input  logic signed [COORD_WIDTH-1:0] i_vec_y,
    input  logic signed [COORD_WIDTH-1:0] i_vec_z,
    output logic                          o_push,
    output c2s_pkg::t_work                o_work,
    input  logic                          i_full
);

    localparam int SC  = 54 - COORD_WIDTH;
    localparam int SQW = 2 * COORD_WIDTH;

    logic w_en;

    // stage 1
    logic                     r1_vld;
    logic [COORD_WIDTH-1:0]   r1_ax, r1_ay, r1_az;
    c2s_pkg::t_flags          r1_flags;
    c2s_pkg::t_rot            r1_azi;
    logic [COORD_WIDTH-1:0]   n1_ax, n1_ay, n1_az;
    c2s_pkg::t_flags          n1_flags;
    c2s_pkg::t_rot            n1_azi;
    logic signed [COORD_WIDTH:0] w_yx, w_yy;

    // stage 2
    logic                     r2_vld;
    logic [SQW-1:0]           r2_sx, r2_sy, r2_sz;
    logic [COORD_WIDTH-1:0]   r2_az;
    c2s_pkg::t_flags          r2_flags;
    c2s_pkg::t_rot            r2_azi;

    // stage 3
    logic                        r3_vld;
    logic [c2s_pkg::RAD_W-1:0]   r3_n2, r3_n3;
    logic [COORD_WIDTH-1:0]      r3_az;
    c2s_pkg::t_flags             r3_flags;
    c2s_pkg::t_rot               r3_azi;

    // stage 4
    logic                        r4_vld;
    logic [c2s_pkg::RAD_W-1:0]   r4_n2, r4_n3;
    logic [COORD_WIDTH-1:0]      r4_az;
    logic [4:0]                  r4_k;
    logic                        r4_big;
    c2s_pkg::t_flags             r4_flags;
    c2s_pkg::t_rot               r4_azi;
    logic [5:0]                  w_p, w_q, w_lim;
    logic [4:0]                  w_k1, n4_k;

    // stage 5
    logic                        r5_vld;
    c2s_pkg::t_work              r5_work;
    c2s_pkg::t_work              n5_work;

    assign w_en    = !(r5_vld && i_full);
    assign o_stall = r5_vld && i_full;
    assign o_push  = r5_vld && !i_full;
    assign o_work  = r5_work;

    always_comb begin
        n1_ax = i_vec_x[COORD_WIDTH-1] ? COORD_WIDTH'(-i_vec_x) : COORD_WIDTH'(i_vec_x);
        n1_ay = i_vec_y[COORD_WIDTH-1] ? COORD_WIDTH'(-i_vec_y) : COORD_WIDTH'(i_vec_y);
        n1_az = i_vec_z[COORD_WIDTH-1] ? COORD_WIDTH'(-i_vec_z) : COORD_WIDTH'(i_vec_z);
        n1_flags.x_zero  = (i_vec_x == '0);
        n1_flags.y_zero  = (i_vec_y == '0);
        n1_flags.z_zero  = (i_vec_z == '0);
        n1_flags.x_neg   = i_vec_x[COORD_WIDTH-1];
        n1_flags.z_pos   = !i_vec_z[COORD_WIDTH-1] && (i_vec_z != '0);
        n1_flags.n2_zero = n1_flags.x_zero && n1_flags.y_zero;
        n1_flags.zero    = n1_flags.n2_zero && n1_flags.z_zero;
        // mirror into the right half-plane for the azimuth CORDIC
        w_yx     = (COORD_WIDTH + 1)'(i_vec_y);
        w_yy     = i_vec_x[COORD_WIDTH-1] ? -w_yx : w_yx;
        n1_azi.x = c2s_pkg::CXW'(n1_ax) << SC;
        n1_azi.y = c2s_pkg::CXW'(w_yy) <<< SC;
        n1_azi.a = '0;
    end

    // normalize shift for the polar root operand
    always_comb begin
        w_p   = c2s_pkg::msb_index(r3_n2);
        w_q   = c2s_pkg::bit_len(c2s_pkg::CW_MAX'(r3_az));
        w_k1  = (w_p >= 6'd60) ? 5'd0 : 5'((6'd61 - w_p) >> 1);
        w_lim = 6'd56 - w_q;
        n4_k  = ({1'b0, w_k1} < w_lim) ? w_k1 : w_lim[4:0];
    end

    always_comb begin
        n5_work.flags = r4_flags;
        n5_work.n3    = r4_n3;
        n5_work.azi   = r4_azi;
        if (r4_big) begin
            n5_work.m  = r4_n2 >> 2;
            n5_work.zf = c2s_pkg::ZF_W'(r4_az >> 1);
        end else begin
            n5_work.m  = r4_n2 << {r4_k, 1'b0};
            n5_work.zf = c2s_pkg::ZF_W'(r4_az) << r4_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax    <= n1_ax;
            r1_ay    <= n1_ay;
            r1_az    <= n1_az;
            r1_flags <= n1_flags;
            r1_azi   <= n1_azi;

            r2_sx    <= SQW'(r1_ax) * SQW'(r1_ax);
            r2_sy    <= SQW'(r1_ay) * SQW'(r1_ay);
            r2_sz    <= SQW'(r1_az) * SQW'(r1_az);
            r2_az    <= r1_az;
            r2_flags <= r1_flags;
            r2_azi   <= r1_azi;

            r3_n2    <= c2s_pkg::RAD_W'(r2_sx) + c2s_pkg::RAD_W'(r2_sy);
            r3_n3    <= c2s_pkg::RAD_W'(r2_sx) + c2s_pkg::RAD_W'(r2_sy)
                        + c2s_pkg::RAD_W'(r2_sz);
            r3_az    <= r2_az;
            r3_flags <= r2_flags;
            r3_azi   <= r2_azi;

            r4_n2    <= r3_n2;
            r4_n3    <= r3_n3;
            r4_az    <= r3_az;
            r4_k     <= n4_k;
            r4_big   <= (r3_n2[c2s_pkg::RAD_W-1:c2s_pkg::RAD_W-2] != 2'b00);
            r4_flags <= r3_flags;
            r4_azi   <= r3_azi;

            r5_work  <= n5_work;
        end
    end

endmodule

// ===== design/c2s_queue.sv =====
// ----------------------------------------------------------------------------
// c2s_queue: short FIFO between front and back ends
// Lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
module c2s_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  c2s_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output c2s_pkg::t_work o_data
);

    localparam int DEPTH = c2s_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    c2s_pkg::t_work    r_mem [DEPTH];
    logic [PW-1:0]     r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

// ===== design/c2s_back.sv =====
// ----------------------------------------------------------------------------
// c2s_back: arithmetic pipeline
// Two digit-by-digit square roots in lockstep, then two vectoring CORDICs,
// then angle assembly, rounding, clamping and the output register.
// ----------------------------------------------------------------------------
module c2s_back #(
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  c2s_pkg::t_work                      i_data,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [c2s_pkg::RADIUS_W-1:0]        o_radius,
    output logic [c2s_pkg::POLAR_W-1:0]         o_polar_deg,
    output logic signed [c2s_pkg::AZIM_W-1:0]   o_azimuth_deg,
    output logic                                o_zero_vector
);

    localparam int SQ = c2s_pkg::SQ_STEPS;
    localparam int L  = SQ + CORDIC_STAGES;

    function automatic c2s_pkg::t_stage stage_step(input c2s_pkg::t_stage s, input int j);
        c2s_pkg::t_stage o;
        c2s_pkg::t_rot   p;
        o = s;
        p = s.pol_rot;
        if (j < SQ) begin
            o.rad_sq = c2s_pkg::sqrt_step(s.rad_sq, SQ - 1 - j);
            o.pol_sq = c2s_pkg::sqrt_step(s.pol_sq, SQ - 1 - j);
        end else begin
            if (j == SQ) begin
                // polar vector is (|z| scaled, rho)
                p.x = c2s_pkg::CXW'(s.zf);
                p.y = c2s_pkg::CXW'(s.pol_sq.root);
                p.a = '0;
            end
            o.pol_rot = c2s_pkg::cordic_step(p, j - SQ);
            o.azi_rot = c2s_pkg::cordic_step(s.azi_rot, j - SQ);
        end
        return o;
    endfunction

    logic                   w_en;
    logic [L-1:0]           r_vld;
    c2s_pkg::t_stage        r_st [L];
    c2s_pkg::t_stage        n_st [L];
    c2s_pkg::t_stage        w_entry;

    logic                   r_fin_vld;
    c2s_pkg::t_fin          r_fin;
    c2s_pkg::t_fin          n_fin;

    logic                                r_out_vld;
    logic [c2s_pkg::RADIUS_W-1:0]        r_out_radius, n_out_radius;
    logic [c2s_pkg::POLAR_W-1:0]         r_out_polar, n_out_polar;
    logic signed [c2s_pkg::AZIM_W-1:0]   r_out_azim, n_out_azim;
    logic                                r_out_zero;
    logic signed [c2s_pkg::AW-1:0]       w_p16, w_a16;

    assign w_en  = !r_out_vld || !i_stall;
    assign o_pop = w_en && !i_empty;

    always_comb begin
        w_entry             = '0;
        w_entry.flags       = i_data.flags;
        w_entry.rad_sq.rem  = i_data.n3;
        w_entry.pol_sq.rem  = i_data.m;
        w_entry.zf          = i_data.zf;
        w_entry.azi_rot     = i_data.azi;
    end

    for (genvar j = 0; j < L; j++) begin : g_stage
        if (j == 0) begin : g_first
            assign n_st[j] = stage_step(w_entry, j);
        end else begin : g_next
            assign n_st[j] = stage_step(r_st[j-1], j);
        end
    end

    always_comb begin
        n_fin.flags = r_st[L-1].flags;
        // round to nearest: bump when remainder exceeds root
        n_fin.rad = {1'b0, r_st[L-1].rad_sq.root}
                    + ((r_st[L-1].rad_sq.rem > c2s_pkg::RAD_W'(r_st[L-1].rad_sq.root))
                       ? (c2s_pkg::ROOT_W + 1)'(1) : '0);
        n_fin.pol = r_st[L-1].flags.z_pos ? r_st[L-1].pol_rot.a
                                          : c2s_pkg::DEG180_Q24 - r_st[L-1].pol_rot.a;
        n_fin.azi = r_st[L-1].azi_rot.a
                    + (r_st[L-1].flags.x_neg ? c2s_pkg::DEG180_Q24 : '0);
    end

    always_comb begin
        w_p16 = (r_fin.pol + c2s_pkg::RND_HALF) >>> 8;
        w_a16 = (r_fin.azi + c2s_pkg::RND_HALF) >>> 8;

        if (r_fin.rad > (c2s_pkg::ROOT_W + 1)'(c2s_pkg::RADIUS_MAX)) begin
            n_out_radius = c2s_pkg::RADIUS_MAX;
        end else begin
            n_out_radius = r_fin.rad[c2s_pkg::RADIUS_W-1:0];
        end

        if (r_fin.flags.zero) begin
            n_out_polar = '0;
        end else if (r_fin.flags.n2_zero) begin
            n_out_polar = r_fin.flags.z_pos ? '0 : c2s_pkg::DEG180_Q16[c2s_pkg::POLAR_W-1:0];
        end else if (r_fin.flags.z_zero) begin
            n_out_polar = c2s_pkg::DEG90_Q16[c2s_pkg::POLAR_W-1:0];
        end else if (w_p16 < 0) begin
            n_out_polar = '0;
        end else if (w_p16 > c2s_pkg::POLAR_MAX) begin
            n_out_polar = c2s_pkg::POLAR_MAX[c2s_pkg::POLAR_W-1:0];
        end else begin
            n_out_polar = w_p16[c2s_pkg::POLAR_W-1:0];
        end

        if (r_fin.flags.zero || r_fin.flags.x_zero) begin
            n_out_azim = '0;
        end else if (r_fin.flags.y_zero) begin
            n_out_azim = r_fin.flags.x_neg ? c2s_pkg::DEG180_Q16[c2s_pkg::AZIM_W-1:0] : '0;
        end else if (w_a16 < c2s_pkg::AZ_MIN) begin
            n_out_azim = c2s_pkg::AZ_MIN[c2s_pkg::AZIM_W-1:0];
        end else if (w_a16 > c2s_pkg::AZ_MAX) begin
            n_out_azim = c2s_pkg::AZ_MAX[c2s_pkg::AZIM_W-1:0];
        end else begin
            n_out_azim = w_a16[c2s_pkg::AZIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[L-2:0], !i_empty};
            r_fin_vld <= r_vld[L-1];
            r_out_vld <= r_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < L; j++) begin
                r_st[j] <= n_st[j];
            end
            r_fin        <= n_fin;
            r_out_radius <= n_out_radius;
            r_out_polar  <= n_out_polar;
            r_out_azim   <= n_out_azim;
            r_out_zero   <= r_fin.flags.zero;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_radius      = r_out_radius;
    assign o_polar_deg   = r_out_polar;
    assign o_azimuth_deg = r_out_azim;
    assign o_zero_vector = r_out_zero;

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> r_out_vld && $stable(r_vld) && $stable(r_fin_vld))
        else $error("pipeline moved while output word stalled");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_zero |-> r_out_radius == '0 && r_out_polar == '0
                                    && r_out_azim == '0)
        else $error("zero vector with nonzero result");

    a_polar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_polar <= c2s_pkg::POLAR_MAX[c2s_pkg::POLAR_W-1:0])
        else $error("polar angle above 180 degrees");

endmodule

// ===== design/cartesian_to_spherical.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical: signed 3D vector to radius, polar and azimuth
// Input channel: i_valid / o_stall with i_vec_x, i_vec_y, i_vec_z; a word is
// taken on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_radius, o_polar_deg (degrees Q16,
// 0..180), o_azimuth_deg (degrees Q16, -90..270) and o_zero_vector.
// Throughput: one word per cycle, sustained, while the receiver keeps up.
// Pipeline: the 32 digit steps of the square roots and the CORDIC stages,
// plus five front-end stages, the queue and the output stages, lie between
// an input word and its output word.
// A four-word queue sits between the front end and the arithmetic pipeline.
// When i_stall is high with o_valid set, the output word holds and the
// arithmetic pipeline freezes; the front end keeps taking words until the
// queue fills, then raises o_stall.
// Reset (i_rst_n low, synchronous) empties every stage and the queue; no
// word is in flight afterwards.
// ----------------------------------------------------------------------------
module cartesian_to_spherical #(
    parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_vec_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vec_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vec_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [c2s_pkg::RADIUS_W-1:0]        o_radius,
    output logic [c2s_pkg::POLAR_W-1:0]         o_polar_deg,
    output logic signed [c2s_pkg::AZIM_W-1:0]   o_azimuth_deg,
    output logic                                o_zero_vector
);

    logic           w_push, w_full, w_pop, w_empty;
    c2s_pkg::t_work w_push_data, w_pop_data;

    c2s_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .o_push  (w_push),
        .o_work  (w_push_data),
        .i_full  (w_full)
    );

    c2s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_data)
    );

    c2s_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_data        (w_pop_data),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_radius      (o_radius),
        .o_polar_deg   (o_polar_deg),
        .o_azimuth_deg (o_azimuth_deg),
        .o_zero_vector (o_zero_vector)
    );

endmodule

// ===== test/tb_cartesian_to_spherical.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_spherical: self-checking bench for the vector converter
// Drives signed 3D vectors over valid/stall, predicts radius, polar angle,
// azimuth and the zero flag with an independent CORDIC model, and compares
// each output word in order against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct {
    logic [23:0]        radius;
    logic [23:0]        polar;
    logic signed [25:0] azim;
    logic               zero;
} t_sph;

class sph_scoreboard;
    t_sph pending[$];
    int   errors;

    function new();
        errors = 0;
    endfunction

    static function longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitw;
        root = 0;
        bitw = 64'd1 << 62;
        while (bitw > n) bitw = bitw >> 2;
        while (bitw != 0) begin
            if (n >= root + bitw) begin
                n = n - (root + bitw);
                root = (root >> 1) + bitw;
            end else begin
                root = root >> 1;
            end
            bitw = bitw >> 2;
        end
        return root;
    endfunction

    static function longint atan_deg(int i);
        longint tbl[32] = '{754974720, 445687602, 235489088, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
            117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
            29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    // vectoring CORDIC, angle in degrees Q24
    static function longint vector_angle(longint cx, longint cy);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        for (int i = 0; i < 24; i++) begin
            dx = shr_arith(cy, i);
            dy = shr_arith(cx, i);
            if (cy >= 0) begin
                cx += dx; cy -= dy; acc += atan_deg(i);
            end else begin
                cx -= dx; cy += dy; acc -= atan_deg(i);
            end
        end
        return acc;
    endfunction

    static function t_sph convert(logic signed [23:0] vx, logic signed [23:0] vy,
                                  logic signed [23:0] vz);
        t_sph            res;
        longint          x, y, z, pol, az, rho, zf, a, yy;
        longint unsigned ax, ay, azz, n2, n3, r;
        int              k;
        x = vx; y = vy; z = vz;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        azz = z < 0 ? -z : z;
        n2 = ax * ax + ay * ay;
        n3 = n2 + azz * azz;
        r = int_sqrt(n3);
        if (r * r + r < n3) r++;
        if (r > 64'hFFFFFF) r = 64'hFFFFFF;
        pol = 0; az = 0;
        if (n3 != 0) begin
            if (n2 == 0) pol = (z > 0) ? 0 : (64'sd180 << 24);
            else if (z == 0) pol = 64'sd90 << 24;
            else begin
                k = 0;
                if ((n2 >> 62) != 0) begin
                    rho = int_sqrt(n2 >> 2);
                    zf = shr_arith(azz, 1);
                end else begin
                    while (k < 30 && (n2 >> (60 - 2 * k)) == 0) k++;
                    while (k > 0 && (azz >> (56 - k)) != 0) k--;
                    rho = int_sqrt(n2 << (2 * k));
                    zf = azz << k;
                end
                a = vector_angle(zf, rho);
                pol = (z > 0) ? a : (64'sd180 << 24) - a;
            end
            if (x == 0) az = 0;
            else if (y == 0) az = (x > 0) ? 0 : (64'sd180 << 24);
            else begin
                yy = (x < 0) ? -y : y;
                az = vector_angle(longint'(ax) << 30, yy <<< 30);
                if (x < 0) az += 64'sd180 << 24;
            end
        end
        pol = shr_arith(pol + 128, 8);
        az = shr_arith(az + 128, 8);
        if (pol < 0) pol = 0;
        if (pol > 11796480) pol = 11796480;
        if (az < -5898240) az = -5898240;
        if (az > 17694720) az = 17694720;
        res.radius = r[23:0];
        res.polar = pol[23:0];
        res.azim = az[25:0];
        res.zero = (n3 == 0);
        return res;
    endfunction

    function void note_vector(logic signed [23:0] vx, logic signed [23:0] vy,
                              logic signed [23:0] vz);
        pending.push_back(convert(vx, vy, vz));
    endfunction

    function void check_result(t_sph got);
        t_sph want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word r=%0d", $time, got.radius);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.radius !== want.radius) begin
            $display("%0t: radius exp %0d got %0d", $time, want.radius, got.radius);
            errors++;
        end
        if (got.polar !== want.polar) begin
            $display("%0t: polar exp %0d got %0d", $time, want.polar, got.polar);
            errors++;
        end
        if (got.azim !== want.azim) begin
            $display("%0t: azimuth exp %0d got %0d", $time, want.azim, got.azim);
            errors++;
        end
        if (got.zero !== want.zero) begin
            $display("%0t: zero flag exp %0b got %0b", $time, want.zero, got.zero);
            errors++;
        end
    endfunction
endclass

module tb_cartesian_to_spherical;
    localparam int LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [23:0] i_vec_x = '0;
    logic signed [23:0] i_vec_y = '0;
    logic signed [23:0] i_vec_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [23:0]        o_radius;
    logic [23:0]        o_polar_deg;
    logic signed [25:0] o_azimuth_deg;
    logic               o_zero_vector;

    sph_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet = 0;    // no idling in the closing stretch

    cartesian_to_spherical DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: check accepted words, stall in random bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_sph got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.radius = o_radius;
            got.polar = o_polar_deg;
            got.azim = o_azimuth_deg;
            got.zero = o_zero_vector;
            sb.check_result(got);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 12) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_vector(logic signed [23:0] vx, logic signed [23:0] vy,
                               logic signed [23:0] vz);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vec_x <= vx;
        i_vec_y <= vy;
        i_vec_z <= vz;
        do @(posedge i_clk); while (o_stall);
        sb.note_vector(vx, vy, vz);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sd0;
            1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            2: return 24'($signed($urandom_range(0, 64)) - 32);
            3: return 24'($signed($urandom_range(0, 8192)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    localparam logic signed [23:0] PMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] NMAX = 24'sh800000;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed corners
        send_vector(0, 0, 0);
        send_vector(0, 0, 5);
        send_vector(0, 0, -5);
        send_vector(3, 4, 0);
        send_vector(0, 7, 2);
        send_vector(0, -7, -2);
        send_vector(9, 0, 1);
        send_vector(-9, 0, 1);
        send_vector(1, 1, 1);
        send_vector(-1, -1, -1);
        send_vector(-1, 1, 1);
        send_vector(PMAX, PMAX, PMAX);
        send_vector(NMAX, NMAX, NMAX);
        send_vector(NMAX, PMAX, NMAX);
        send_vector(PMAX, NMAX, 0);
        send_vector(NMAX, 0, 0);
        send_vector(0, 0, NMAX);
        send_vector(1, 0, PMAX);
        send_vector(-1, 1, NMAX);
        send_vector(PMAX, 1, -1);
        send_vector(NMAX, -1, 1);
        send_vector(1, NMAX, 1);
        drain();
        for (int n = 0; n < 600; n++) begin
            if (n == 300) drain();
            if (n == 500) quiet = 1;
            send_vector(rand_coord(), rand_coord(), rand_coord());
        end
        drain();
        repeat (120) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
